>>> rtl/quaternion_vector_rotate_macros.svh
// assertion macros for the quaternion rotation pipeline
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset
`define QVR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qvr assertion failed");

// checked on every edge, reset included
`define QVR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("qvr assertion failed");

`else

`define QVR_ASSERT(label, clk, rst, prop)
`define QVR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> rtl/qvr_pkg.sv
`default_nettype none
package qvr_pkg;

  localparam int QUAT_W     = 16;
  localparam int QPROD_W    = 2 * QUAT_W;
  localparam int M_W        = QPROD_W + 2;
  localparam int OUT_W      = 18;
  localparam int NUM_STAGES = 5;

  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int VEC_WIDTH_DEF      = 16;

  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [M_W-1:0]     mat_t;
  typedef logic signed [OUT_W-1:0]   out_t;

  localparam out_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // accumulator width: room for three products plus rounding, and enough
  // bits above the binary point to judge saturation
  function automatic int acc_width(input int vec_w, input int frac_bits);
    int a;
    int b;
    a = M_W + vec_w + 3;
    b = 2 * frac_bits + OUT_W + 1;
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/qvr_ctrl.sv
`default_nettype none
`include "quaternion_vector_rotate_macros.svh"
module qvr_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [qvr_pkg::NUM_STAGES-1:0]      en
);
  import qvr_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] valid_next;

  // a stage may load when it is empty or its word moves on
  always_comb begin
    en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        valid_next[i] = (i == 0) ? in_valid : valid[(i == 0) ? 0 : i - 1];
      end else begin
        valid_next[i] = valid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[NUM_STAGES-1];

  // input only backs up when every stage holds a word
  `QVR_ASSERT(a_stall_full, clk, rst, in_stall |-> (&valid))
  `QVR_ASSERT(a_accept_lands, clk, rst, (in_valid && !in_stall) |=> valid[0])
  `QVR_ASSERT(a_last_moves, clk, rst,
    (valid[NUM_STAGES-2] && en[NUM_STAGES-1]) |=> valid[NUM_STAGES-1])
  `QVR_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (valid == '0))

endmodule
`default_nettype wire

>>> rtl/qvr_matrix.sv
`default_nettype none
module qvr_matrix #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic [1:0]                  en,
  input  wire qvr_pkg::quat_t              quat_w,
  input  wire qvr_pkg::quat_t              quat_x,
  input  wire qvr_pkg::quat_t              quat_y,
  input  wire qvr_pkg::quat_t              quat_z,
  input  wire logic signed [VEC_WIDTH-1:0] vec_in [3],
  output qvr_pkg::mat_t                    m [3][3],
  output logic signed [VEC_WIDTH-1:0]      vec_out [3]
);
  import qvr_pkg::*;

  qprod_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [VEC_WIDTH-1:0] vec_s1 [3];

  // stage 1: the ten quaternion products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
      wy <= quat_w * quat_y;
      wz <= quat_w * quat_z;
      vec_s1 <= vec_in;
    end
  end

  mat_t eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;

  always_comb begin
    eww = M_W'(ww);
    exx = M_W'(xx);
    eyy = M_W'(yy);
    ezz = M_W'(zz);
    exy = M_W'(xy);
    exz = M_W'(xz);
    eyz = M_W'(yz);
    ewx = M_W'(wx);
    ewy = M_W'(wy);
    ewz = M_W'(wz);
  end

  // stage 2: rotation matrix scaled by |q| squared
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m[0][0] <= eww + exx - eyy - ezz;
      m[0][1] <= (exy - ewz) <<< 1;
      m[0][2] <= (exz + ewy) <<< 1;
      m[1][0] <= (exy + ewz) <<< 1;
      m[1][1] <= eww - exx + eyy - ezz;
      m[1][2] <= (eyz - ewx) <<< 1;
      m[2][0] <= (exz - ewy) <<< 1;
      m[2][1] <= (eyz + ewx) <<< 1;
      m[2][2] <= eww - exx - eyy + ezz;
      vec_out <= vec_s1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/qvr_mac.sv
`default_nettype none
module qvr_mac #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic [1:0]                  en,
  input  wire qvr_pkg::mat_t               m [3][3],
  input  wire logic signed [VEC_WIDTH-1:0] vec [3],
  output logic signed [qvr_pkg::acc_width(VEC_WIDTH, QUAT_FRAC_BITS)-1:0] acc [3]
);
  import qvr_pkg::*;

  localparam int P_W   = M_W + VEC_WIDTH;
  localparam int ACC_W = acc_width(VEC_WIDTH, QUAT_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (2 * QUAT_FRAC_BITS - 1);

  logic signed [P_W-1:0] p [3][3];

  // stage 3: nine matrix by vector products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= P_W'(m[i][j]) * P_W'(vec[j]);
        end
      end
    end
  end

  // stage 4: row sums with the half-lsb rounding offset folded in
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACC_W'(p[i][0]) + ACC_W'(p[i][1]) + ACC_W'(p[i][2]) + RND;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/qvr_round.sv
`default_nettype none
module qvr_round #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [qvr_pkg::acc_width(VEC_WIDTH, QUAT_FRAC_BITS)-1:0] acc [3],
  output qvr_pkg::out_t rot [3],
  output logic          clipped
);
  import qvr_pkg::*;

  localparam int ACC_W = acc_width(VEC_WIDTH, QUAT_FRAC_BITS);
  localparam int SH    = 2 * QUAT_FRAC_BITS;

  logic signed [ACC_W-1:0] shifted [3];
  out_t                    sat [3];
  logic [2:0]              clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = acc[i] >>> SH;
      // fits when every bit above the result sign matches it
      if ((&shifted[i][ACC_W-1:OUT_W-1]) || !(|shifted[i][ACC_W-1:OUT_W-1])) begin
        sat[i]  = shifted[i][OUT_W-1:0];
        clip[i] = 1'b0;
      end else begin
        sat[i]  = shifted[i][ACC_W-1] ? OUT_MIN : OUT_MAX;
        clip[i] = 1'b1;
      end
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (en) begin
      rot     <= sat;
      clipped <= |clip;
    end
  end

endmodule
`default_nettype wire

>>> rtl/quaternion_vector_rotate.sv
`default_nettype none
// Rotates (vec_x, vec_y, vec_z) by the quaternion (quat_w, quat_x, quat_y,
// quat_z) as q*(0,v)*conj(q) and returns the vector part, rounded to nearest
// (ties up) and saturated to 18 bits; clipped flags any saturated component.
// q is used as given, so a non-unit q scales the result by |q| squared.
// Five register stages: quaternion products, rotation matrix, nine
// matrix-vector products, row sums, round and saturate; a word moves through
// them in that order to the outputs. A new word can be taken every cycle
// while in_stall is low; in_stall rises only when out_stall has held the
// output long enough for all five stages to fill.
module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire qvr_pkg::quat_t              quat_w,
  input  wire qvr_pkg::quat_t              quat_x,
  input  wire qvr_pkg::quat_t              quat_y,
  input  wire qvr_pkg::quat_t              quat_z,
  input  wire logic signed [VEC_WIDTH-1:0] vec_x,
  input  wire logic signed [VEC_WIDTH-1:0] vec_y,
  input  wire logic signed [VEC_WIDTH-1:0] vec_z,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output qvr_pkg::out_t                    rot_x,
  output qvr_pkg::out_t                    rot_y,
  output qvr_pkg::out_t                    rot_z,
  output logic                             clipped
);
  import qvr_pkg::*;

  localparam int ACC_W = acc_width(VEC_WIDTH, QUAT_FRAC_BITS);

  logic [NUM_STAGES-1:0]       en;
  logic signed [VEC_WIDTH-1:0] vec_in [3];
  logic signed [VEC_WIDTH-1:0] vec_m [3];
  mat_t                        m [3][3];
  logic signed [ACC_W-1:0]     acc [3];
  out_t                        rot [3];

  assign vec_in[0] = vec_x;
  assign vec_in[1] = vec_y;
  assign vec_in[2] = vec_z;

  qvr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  qvr_matrix #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_matrix (
    .clk     (clk),
    .en      (en[1:0]),
    .quat_w  (quat_w),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .vec_in  (vec_in),
    .m       (m),
    .vec_out (vec_m)
  );

  qvr_mac #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_WIDTH      (VEC_WIDTH)
  ) u_mac (
    .clk (clk),
    .en  (en[3:2]),
    .m   (m),
    .vec (vec_m),
    .acc (acc)
  );

  qvr_round #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_WIDTH      (VEC_WIDTH)
  ) u_round (
    .clk     (clk),
    .en      (en[4]),
    .acc     (acc),
    .rot     (rot),
    .clipped (clipped)
  );

  assign rot_x = rot[0];
  assign rot_y = rot[1];
  assign rot_z = rot[2];

endmodule
`default_nettype wire

>>> sim/quaternion_vector_rotate_tb.sv
`default_nettype none
module quaternion_vector_rotate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qvr_pkg::*;

  localparam int FRAC      = QUAT_FRAC_BITS_DEF;
  localparam int RAND_WORDS = 1300;

  typedef logic signed [VEC_WIDTH_DEF-1:0] vec_t;

  typedef struct packed {
    out_t x;
    out_t y;
    out_t z;
    logic clip;
  } rot_word_t;

  class rotation_scoreboard;
    rot_word_t due_rot[$];
    int errors;
    int checked;
    int clips;

    function new();
      errors  = 0;
      checked = 0;
      clips   = 0;
    endfunction

    // exact matrix form of q*(0,v)*conj(q), then round half up and saturate
    function rot_word_t rotate_vec(quat_t qw, quat_t qx, quat_t qy, quat_t qz,
                                   vec_t vx, vec_t vy, vec_t vz);
      longint w, x, y, z;
      longint m[3][3];
      longint v[3];
      longint acc;
      out_t res[3];
      rot_word_t o;
      w = qw;
      x = qx;
      y = qy;
      z = qz;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      m[0][0] = w*w + x*x - y*y - z*z;
      m[0][1] = 2 * (x*y - w*z);
      m[0][2] = 2 * (x*z + w*y);
      m[1][0] = 2 * (x*y + w*z);
      m[1][1] = w*w - x*x + y*y - z*z;
      m[1][2] = 2 * (y*z - w*x);
      m[2][0] = 2 * (x*z - w*y);
      m[2][1] = 2 * (y*z + w*x);
      m[2][2] = w*w - x*x - y*y + z*z;
      o.clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2];
        acc = (acc + (longint'(1) <<< (2*FRAC - 1))) >>> (2*FRAC);
        if (acc > longint'(OUT_MAX)) begin
          res[i] = OUT_MAX;
          o.clip = 1'b1;
        end else if (acc < longint'(OUT_MIN)) begin
          res[i] = OUT_MIN;
          o.clip = 1'b1;
        end else begin
          res[i] = acc[OUT_W-1:0];
        end
      end
      o.x = res[0];
      o.y = res[1];
      o.z = res[2];
      return o;
    endfunction

    function void note_word(quat_t qw, quat_t qx, quat_t qy, quat_t qz,
                            vec_t vx, vec_t vy, vec_t vz);
      due_rot.push_back(rotate_vec(qw, qx, qy, qz, vx, vy, vz));
    endfunction

    function void check_word(out_t rx, out_t ry, out_t rz, logic clip);
      rot_word_t want;
      bit bad;
      if (due_rot.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: x=%0d y=%0d z=%0d clipped=%0b", rx, ry, rz, clip);
        return;
      end
      want = due_rot.pop_front();
      checked++;
      if (want.clip)
        clips++;
      bad = 1'b0;
      if (rx !== want.x)
        bad = 1'b1;
      if (ry !== want.y)
        bad = 1'b1;
      if (rz !== want.z)
        bad = 1'b1;
      if (clip !== want.clip)
        bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("word %0d: want x=%0d y=%0d z=%0d c=%0b, got x=%0d y=%0d z=%0d c=%0b",
                   checked, want.x, want.y, want.z, want.clip, rx, ry, rz, clip);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  quat_t quat_w = '0;
  quat_t quat_x = '0;
  quat_t quat_y = '0;
  quat_t quat_z = '0;
  vec_t vec_x = '0;
  vec_t vec_y = '0;
  vec_t vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t rot_x;
  out_t rot_y;
  out_t rot_z;
  logic clipped;

  rotation_scoreboard sb;
  bit calm = 1'b0;
  int sent = 0;
  int drains = 0;

  quaternion_vector_rotate u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .clipped   (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("quaternion_vector_rotate_tb NOT OK");
    $finish;
  end

  // output side: check accepted words, stall now and then
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_word(rot_x, rot_y, rot_z, clipped);
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  // called at a rising edge; returns at the edge where the word was taken,
  // or after the idle cycle that follows it when there is one
  task automatic push_rotation(input quat_t qw, input quat_t qx, input quat_t qy,
                               input quat_t qz, input vec_t vx, input vec_t vy,
                               input vec_t vz);
    quat_w   <= qw;
    quat_x   <= qx;
    quat_y   <= qy;
    quat_z   <= qz;
    vec_x    <= vx;
    vec_y    <= vy;
    vec_z    <= vz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_word(qw, qx, qy, qz, vx, vy, vz);
    sent++;
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold the sender until the pipeline has delivered everything
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_rot.size() != 0)
      @(posedge clk);
    drains++;
  endtask

  function automatic logic [15:0] pick_field(int mode);
    if (mode == 0)
      return 16'($urandom_range(0, 65535));
    if (mode == 1)
      return 16'(int'($urandom_range(0, 32768)) - 16384);
    case ($urandom_range(0, 6))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h4000;
      default: return 16'hc000;
    endcase
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return 0;
    if (r < 7)
      return 1;
    return 2;
  endfunction

  initial begin
    int qm;
    int vm;
    int waited;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero quaternion, identity both signs, a quarter turn and an exact half turn
    push_rotation(0, 0, 0, 0, 32767, -32768, 32767);
    push_rotation(16384, 0, 0, 0, 32767, -32768, 1);
    push_rotation(-16384, 0, 0, 0, -32768, 32767, -1);
    push_rotation(11585, 0, 0, 11585, 1000, 0, 0);
    push_rotation(0, 16384, 0, 0, 100, 200, 300);
    // ties: +0.5 goes up, -0.5 goes to zero, 1.5 to 2
    push_rotation(128, 0, 0, 0, 8192, -8192, 24576);
    push_rotation(128, 0, 0, 0, -24576, 8192, -8192);
    // non-unit q: scale by four lands just inside, a little more clips
    push_rotation(-32768, 0, 0, 0, 32767, 32767, 32767);
    push_rotation(-32768, 0, 0, 0, -32768, -32768, -32768);
    push_rotation(-32768, 1024, 0, 0, 32767, 0, 0);
    push_rotation(-32768, 1024, 0, 0, -32768, 0, 0);
    push_rotation(-32768, -32768, 0, 0, 32767, 32767, 32767);
    push_rotation(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    push_rotation(-32768, -32768, -32768, -32768, 32767, 32767, 32767);
    push_rotation(32767, 32767, 32767, 32767, 32767, -32768, 32767);
    push_rotation(32767, -32768, 32767, -32768, -32768, 32767, -32768);
    push_rotation(0, 0, 0, 1, 32767, 32767, 32767);
    push_rotation(1, -1, 1, -1, -32768, -1, 1);
    push_rotation(-32768, 32767, -32768, 32767, 0, 0, 0);
    push_rotation(0, 0, 16384, 0, -1, 0, 1);
    drain_pipeline();

    for (int n = 0; n < RAND_WORDS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n == 650)
        drain_pipeline();
      qm = pick_mode();
      vm = pick_mode();
      push_rotation(pick_field(qm), pick_field(qm), pick_field(qm), pick_field(qm),
                    pick_field(vm), pick_field(vm), pick_field(vm));
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    waited = 0;
    while (sb.due_rot.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * NUM_STAGES + 4) @(posedge clk);
    if (sb.due_rot.size() != 0) begin
      $display("%0d words never came out", sb.due_rot.size());
      sb.errors++;
    end

    $display("sent %0d rotations, checked %0d, %0d saturated, %0d mismatches",
             sent, sb.checked, sb.clips, sb.errors);
    $display("covered ties, extremes, non-unit quaternions, %0d full drains", drains);
    if (sb.errors == 0)
      $display("quaternion_vector_rotate_tb OK");
    else
      $display("quaternion_vector_rotate_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/qvr_pkg.sv
rtl/qvr_ctrl.sv
rtl/qvr_matrix.sv
rtl/qvr_mac.sv
rtl/qvr_round.sv
rtl/quaternion_vector_rotate.sv
sim/quaternion_vector_rotate_tb.sv
